// ===== sv/bitmap_font_text_renderer_top_defines.svh =====
// Assertion macros for the bitmap font text renderer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BITMAP_FONT_TEXT_RENDERER_TOP_DEFINES_SVH
`define BITMAP_FONT_TEXT_RENDERER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define BFR_ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`define BFR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BFR_ASSERT_IMPLIES(lbl, pre, post, msg)

`define BFR_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== sv/bfr_pkg.sv =====
package bfr_pkg;

    // Request kinds carried on the slave-side tuser.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CURSOR = 2'd1,
        OP_DRAW   = 2'd2
    } op_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LINE_STRIDE = 3'd0;
    localparam logic [2:0] CFG_CLIP_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_CLIP_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_FG_COLOR    = 3'd3;
    localparam logic [2:0] CFG_BG_COLOR    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [12:0] LINE_STRIDE_RST = 13'd640;
    localparam logic [11:0] CLIP_WIDTH_RST  = 12'd640;
    localparam logic [11:0] CLIP_HEIGHT_RST = 12'd476;
    localparam logic [15:0] FG_COLOR_RST    = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RST    = 16'h0000;

    // Glyph geometry.
    localparam int GLYPH_W     = 12;
    localparam int GLYPH_H     = 24;
    localparam int HALF_W      = 6;
    localparam int GLYPH_BYTES = 36;

    // Character codes.
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_FIRST   = 8'd33;
    localparam logic [7:0] CHAR_LAST    = 8'd126;
    localparam logic [7:0] CHAR_BASE    = 8'd32;

endpackage

// ===== sv/bitmap_font_text_renderer_top.sv =====
// Bitmap font text renderer: draws 12x24 one-bit glyphs as 16-bit pixels.
// Requests arrive on the slave stream; tuser selects a font byte load, a
// cursor set or a character draw. Loads and cursor sets leave the sequencer idle.
// A printable character (33 to 126) emits one master-stream transaction per
// visible half-row of six pixels, with its framebuffer offset and write mask;
// tlast marks the final half-row of the character. Newline and other codes
// only move the cursor and emit nothing.
// A draw first goes through setup (the cursor-to-offset multiply, the clip
// masks and the visible row count), then sends one half-row per cycle while
// the receiver does not stall, skipping the right half when it is clipped.
// Each half-row passes the memory read register and then the output register.
// The rate is set by the font memory: two byte-wide banks, even and odd
// addresses, each read once per cycle, which together deliver the two bytes
// that one half-row can span.
// A new request is taken once the sequencer has issued its last read.
// While the receiver stalls, one half-row waits in the output register and
// one in the memory read register, and the sequencer stops issuing reads.
// Reset clears the cursor and all valid flags and sets the configuration registers to their reset values;
// the font memory is not cleared and must be loaded before it is drawn from.
`include "bitmap_font_text_renderer_top_defines.svh"

module bitmap_font_text_renderer_top #(
    parameter int GLYPH_COUNT = 288
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [13:0] font_address, [21:14] font_byte, [29:22] cursor_row_in,
    // [37:30] cursor_col_in, [45:38] character, [47:46] zero
    input  logic [47:0]  s_tdata,
    // [1:0] operation
    input  logic [1:0]   s_tuser,
    // pixel stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] pixel_offset, [39:24] pixel_a, [55:40] pixel_b, [71:56] pixel_c,
    // [87:72] pixel_d, [103:88] pixel_e, [119:104] pixel_f,
    // [125:120] write_mask, [127:126] zero
    output logic [127:0] m_tdata,
    output logic         m_tlast
);

    localparam int FONT_BYTES = GLYPH_COUNT * bfr_pkg::GLYPH_BYTES;
    localparam int BANK_DEPTH = FONT_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int FONT_AW    = BANK_AW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    // ---------------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------------
    bfr_pkg::op_t op;
    logic [13:0]  font_address;
    logic [7:0]   font_byte;
    logic [7:0]   cursor_row_in;
    logic [7:0]   cursor_col_in;
    logic [7:0]   character;
    logic         accept;
    logic [31:0]  load_addr;
    logic         font_we;

    assign op            = bfr_pkg::op_t'(s_tuser);
    assign font_address  = s_tdata[13:0];
    assign font_byte     = s_tdata[21:14];
    assign cursor_row_in = s_tdata[29:22];
    assign cursor_col_in = s_tdata[37:30];
    assign character     = s_tdata[45:38];
    assign load_addr     = 32'(font_address);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [12:0] line_stride_reg;
    logic [11:0] clip_width_reg;
    logic [11:0] clip_height_reg;
    logic [15:0] fg_color_reg;
    logic [15:0] bg_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_stride_reg <= bfr_pkg::LINE_STRIDE_RST;
            clip_width_reg  <= bfr_pkg::CLIP_WIDTH_RST;
            clip_height_reg <= bfr_pkg::CLIP_HEIGHT_RST;
            fg_color_reg    <= bfr_pkg::FG_COLOR_RST;
            bg_color_reg    <= bfr_pkg::BG_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfr_pkg::CFG_LINE_STRIDE: line_stride_reg <= cfg_data[12:0];
                bfr_pkg::CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_data[11:0];
                bfr_pkg::CFG_CLIP_HEIGHT: clip_height_reg <= cfg_data[11:0];
                bfr_pkg::CFG_FG_COLOR:    fg_color_reg    <= cfg_data;
                bfr_pkg::CFG_BG_COLOR:    bg_color_reg    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer registers
    // ---------------------------------------------------------------------
    state_t              state_reg,    state_next;
    logic [7:0]          text_row_reg, text_row_next;
    logic [7:0]          text_col_reg, text_col_next;
    logic [11:0]         x_reg,        x_next;
    logic [12:0]         y_reg,        y_next;
    logic [FONT_AW-1:0]  base_reg,     base_next;
    logic [23:0]         row_off_reg,  row_off_next;
    logic [5:0]          mask0_reg,    mask0_next;
    logic [5:0]          mask1_reg,    mask1_next;
    logic [4:0]          last_row_reg, last_row_next;
    logic [4:0]          r_reg,        r_next;
    logic                h_reg,        h_next;

    // Read stage (memory output plus the half-row it belongs to)
    logic                dv_reg,       dv_next;
    logic [2:0]          d_bit_reg;
    logic                d_swap_reg;
    logic [5:0]          d_mask_reg;
    logic [23:0]         d_offset_reg;
    logic                d_last_reg;
    logic [7:0]          even_q_reg;
    logic [7:0]          odd_q_reg;

    // Output register
    logic                ov_reg,       ov_next;
    logic [23:0]         out_offset_reg;
    logic [15:0]         out_pix_reg [6];
    logic [5:0]          out_mask_reg;
    logic                out_last_reg;

    // Setup arithmetic
    logic [25:0]         prod;
    logic [11:0]         vis;
    logic [12:0]         rows_avail;
    logic                rows_any;

    // Half-row addressing
    logic [5:0]          cur_mask;
    logic                skip;
    logic                load_out;
    logic                adv;
    logic                issue;
    logic                final_half;
    logic [8:0]          start_bit;
    logic [FONT_AW-1:0]  rd_addr;
    logic [BANK_AW-1:0]  rd_row;
    logic [BANK_AW-1:0]  even_addr;

    // Pixel selection
    logic [15:0]         pair;
    logic [15:0]         pair_sh;
    logic [5:0]          bits;
    logic [15:0]         pix [6];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign font_we  = accept && (op == bfr_pkg::OP_LOAD) && (load_addr < 32'(FONT_BYTES));

    assign prod = 26'(y_reg) * 26'(line_stride_reg);

    always_comb
    begin
        for (int c = 0; c < bfr_pkg::GLYPH_W; c++)
        begin
            vis[c] = (13'(x_reg) + 13'(c)) < 13'(clip_width_reg);
        end
    end

    assign rows_any   = y_reg < 13'(clip_height_reg);
    assign rows_avail = 13'(clip_height_reg) - y_reg;

    assign cur_mask   = h_reg ? mask1_reg : mask0_reg;
    assign skip       = (cur_mask == 6'd0);
    assign load_out   = dv_reg && (!ov_reg || m_tready);
    assign adv        = (state_reg == ST_RUN) && (skip || !dv_reg || load_out);
    assign issue      = adv && !skip;
    assign final_half = (r_reg == last_row_reg) && (h_reg || (mask1_reg == 6'd0));

    // First bit of the half-row inside the glyph: 12 * row + 6 * half.
    assign start_bit = 9'({r_reg, 3'b000}) + 9'({r_reg, 2'b00}) + (h_reg ? 9'd6 : 9'd0);
    assign rd_addr   = base_reg + FONT_AW'(start_bit[8:3]);
    assign rd_row    = rd_addr[FONT_AW-1:1];
    // An odd first byte lives in the odd bank; its successor is the next even row.
    assign even_addr = rd_addr[0] ? rd_row + BANK_AW'(1) : rd_row;

    always_comb
    begin
        state_next    = state_reg;
        text_row_next = text_row_reg;
        text_col_next = text_col_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        base_next     = base_reg;
        row_off_next  = row_off_reg;
        mask0_next    = mask0_reg;
        mask1_next    = mask1_reg;
        last_row_next = last_row_reg;
        r_next        = r_reg;
        h_next        = h_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        bfr_pkg::OP_CURSOR:
                        begin
                            text_row_next = cursor_row_in;
                            text_col_next = cursor_col_in;
                        end
                        bfr_pkg::OP_DRAW:
                        begin
                            if (character == bfr_pkg::CHAR_NEWLINE)
                            begin
                                text_col_next = 8'd0;
                                text_row_next = text_row_reg + 8'd1;
                            end
                            else
                            begin
                                text_col_next = text_col_reg + 8'd1;
                                if (character >= bfr_pkg::CHAR_FIRST &&
                                    character <= bfr_pkg::CHAR_LAST)
                                begin
                                    x_next = 12'({text_col_reg, 3'b000})
                                           + 12'({text_col_reg, 2'b00});
                                    y_next = 13'({text_row_reg, 4'b0000})
                                           + 13'({text_row_reg, 3'b000});
                                    // Glyph (character - 32) starts at 36 bytes per glyph.
                                    base_next = FONT_AW'({character - bfr_pkg::CHAR_BASE, 5'b0})
                                              + FONT_AW'({character - bfr_pkg::CHAR_BASE, 2'b0});
                                    state_next = ST_SETUP;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SETUP:
            begin
                row_off_next = 24'(prod + 26'(x_reg));
                mask0_next   = vis[5:0];
                mask1_next   = vis[11:6];
                if (rows_avail >= 13'(bfr_pkg::GLYPH_H))
                begin
                    last_row_next = 5'(bfr_pkg::GLYPH_H - 1);
                end
                else
                begin
                    last_row_next = rows_avail[4:0] - 5'd1;
                end
                r_next = 5'd0;
                h_next = 1'b0;
                // Nothing to send when the glyph lies below the clip height or
                // its left edge is already past the clip width.
                if (rows_any && (vis[0] != 1'b0))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_RUN:
            begin
                if (adv)
                begin
                    if (final_half)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!h_reg)
                    begin
                        h_next = 1'b1;
                    end
                    else
                    begin
                        h_next       = 1'b0;
                        r_next       = r_reg + 5'd1;
                        row_off_next = row_off_reg + 24'(line_stride_reg);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dv_next = issue ? 1'b1 : (load_out ? 1'b0 : dv_reg);
    assign ov_next = load_out ? 1'b1 : (m_tready ? 1'b0 : ov_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            text_row_reg <= 8'd0;
            text_col_reg <= 8'd0;
            r_reg        <= 5'd0;
            h_reg        <= 1'b0;
            dv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            text_row_reg <= text_row_next;
            text_col_reg <= text_col_next;
            r_reg        <= r_next;
            h_reg        <= h_next;
            dv_reg       <= dv_next;
            ov_reg       <= ov_next;
        end
    end

    // Draw context, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        base_reg     <= base_next;
        row_off_reg  <= row_off_next;
        mask0_reg    <= mask0_next;
        mask1_reg    <= mask1_next;
        last_row_reg <= last_row_next;
    end

    // ---------------------------------------------------------------------
    // Font memory: two banks, even and odd byte addresses
    // ---------------------------------------------------------------------
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (font_we && !load_addr[0])
        begin
            even_mem[load_addr[BANK_AW:1]] <= font_byte;
        end
        if (issue)
        begin
            even_q_reg <= even_mem[even_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (font_we && load_addr[0])
        begin
            odd_mem[load_addr[BANK_AW:1]] <= font_byte;
        end
        if (issue)
        begin
            odd_q_reg <= odd_mem[rd_row];
        end
    end

    // Half-row description that travels beside the memory read.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            d_bit_reg    <= start_bit[2:0];
            d_swap_reg   <= rd_addr[0];
            d_mask_reg   <= cur_mask;
            d_offset_reg <= row_off_reg + (h_reg ? 24'(bfr_pkg::HALF_W) : 24'd0);
            d_last_reg   <= final_half;
        end
    end

    // ---------------------------------------------------------------------
    // Pixel selection and output register
    // ---------------------------------------------------------------------
    assign pair    = d_swap_reg ? {odd_q_reg, even_q_reg} : {even_q_reg, odd_q_reg};
    assign pair_sh = pair << d_bit_reg;
    assign bits    = pair_sh[15:10];

    always_comb
    begin
        for (int i = 0; i < bfr_pkg::HALF_W; i++)
        begin
            if (!d_mask_reg[i])
            begin
                pix[i] = 16'd0;
            end
            else if (bits[bfr_pkg::HALF_W - 1 - i])
            begin
                pix[i] = fg_color_reg;
            end
            else
            begin
                pix[i] = bg_color_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_offset_reg <= d_offset_reg;
            out_mask_reg   <= d_mask_reg;
            out_last_reg   <= d_last_reg;
            for (int i = 0; i < bfr_pkg::HALF_W; i++)
            begin
                out_pix_reg[i] <= pix[i];
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_mask_reg,
                       out_pix_reg[5], out_pix_reg[4], out_pix_reg[3],
                       out_pix_reg[2], out_pix_reg[1], out_pix_reg[0],
                       out_offset_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `BFR_ASSERT_NEXT(a_read_hold, dv_reg && !load_out, dv_reg && $stable(even_q_reg) && $stable(odd_q_reg), "font read data changed while its half-row was waiting")
    `BFR_ASSERT_IMPLIES(a_visible, m_tvalid, m_tdata[125:120] != 6'd0, "half-row sent with an empty write mask")
    `BFR_ASSERT_NEXT(a_final_idle, issue && final_half, state_reg == ST_IDLE, "sequencer kept running after the final half-row")
    `BFR_ASSERT_IMPLIES(a_no_overlap, font_we, !issue, "font load taken while a draw read was issued")

endmodule
